FILE: rtl/olte_pkg.sv
// shared types and constants for the ordered list table engine
// no dependencies; imported by every module of the block

package olte_pkg;

  // list capacity and derived widths
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 2;
  localparam int FND_W  = 6;
  localparam int TOT_W  = 6;
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_VAL   = 3'd3,
    CMD_DEL_AT    = 3'd4,
    CMD_SEARCH    = 3'd5,
    CMD_PALIN     = 3'd6
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_CHK,
    S_UP_WR,
    S_DN_CHK,
    S_DN_WR,
    S_SC_CHK,
    S_SC_CMP,
    S_PA_RDA,
    S_PA_RDB,
    S_PA_CMP,
    S_FIN
  } state_t;

  // index register updates
  typedef enum logic [2:0] {
    K_HOLD, K_ZERO, K_COUNT, K_POSM1, K_INC, K_DEC
  } kop_t;

  typedef enum logic [2:0] {
    J_HOLD, J_ZERO, J_COUNT, J_POSM1, J_LAST, J_DEC
  } jop_t;

  // store read address select
  typedef enum logic [1:0] {
    RD_K, RD_KM1, RD_KP1, RD_J
  } rsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    kop_t    k_op;
    jop_t    j_op;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    hold_ld;
    logic    res_ld;
    status_t res_status;
    logic    res_found;
    logic    res_pal;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic pal_go;
    logic k_gt_j;
    logic k_lt_j;
    logic k_lt_cnt;
    logic kp1_lt_cnt;
    logic match;
    logic differ;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/olte_datapath.sv
// datapath: list store, entry count, index registers and result register
// depends on olte_pkg; driven by olte_ctrl

module olte_datapath
  import olte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_ctl_t               ctl,
  output dp_stat_t              stat,
  input  logic [VAL_W-1:0]      in_value,
  input  logic [POS_W-1:0]      in_position,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata_r;
  logic [VAL_W-1:0]  hold_r;
  logic [VAL_W-1:0]  val_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  rd_idx;
  logic [CMP_W-1:0]  pos_w, cnt_w;

  logic              out_valid_r;
  logic [STS_W-1:0]  res_status_r;
  logic [FND_W-1:0]  res_found_r;
  logic              res_pal_r;
  logic [TOT_W-1:0]  res_total_r;

  assign pos_w  = CMP_W'(pos_r);
  assign cnt_w  = CMP_W'(count_r);
  assign pos_m1 = CNT_W'(pos_r - POS_W'(1));

  // status toward the controller
  always_comb begin
    stat.full       = (count_r == CNT_W'(DEPTH));
    stat.ins_pos_ok = (pos_r != '0) && (pos_w <= cnt_w + CMP_W'(1));
    stat.del_pos_ok = (pos_r != '0) && (pos_w <= cnt_w);
    stat.pal_go     = (count_r >= CNT_W'(2));
    stat.k_gt_j     = (k_r > j_r);
    stat.k_lt_j     = (k_r < j_r);
    stat.k_lt_cnt   = (k_r < count_r);
    stat.kp1_lt_cnt = ((CMP_W'(k_r) + CMP_W'(1)) < cnt_w);
    stat.match      = (rdata_r == val_r);
    stat.differ     = (rdata_r != hold_r);
    stat.out_busy   = out_valid_r && !out_tready;
  end

  always_comb begin
    case (ctl.k_op)
      K_ZERO:  k_nxt = '0;
      K_COUNT: k_nxt = count_r;
      K_POSM1: k_nxt = pos_m1;
      K_INC:   k_nxt = k_r + CNT_W'(1);
      K_DEC:   k_nxt = k_r - CNT_W'(1);
      default: k_nxt = k_r;
    endcase
    case (ctl.j_op)
      J_ZERO:  j_nxt = '0;
      J_COUNT: j_nxt = count_r;
      J_POSM1: j_nxt = pos_m1;
      J_LAST:  j_nxt = count_r - CNT_W'(1);
      J_DEC:   j_nxt = j_r - CNT_W'(1);
      default: j_nxt = j_r;
    endcase
    case (ctl.rd_sel)
      RD_KM1:  rd_idx = k_r - CNT_W'(1);
      RD_KP1:  rd_idx = k_r + CNT_W'(1);
      RD_J:    rd_idx = j_r;
      default: rd_idx = k_r;
    endcase
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // list store, one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[k_r[ADDR_W-1:0]] <= ctl.wr_val ? val_r : rdata_r;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    j_r <= j_nxt;
    if (ctl.capture) begin
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (ctl.hold_ld) begin
      hold_r <= rdata_r;
    end
    if (ctl.res_ld) begin
      res_status_r <= ctl.res_status;
      res_found_r  <= ctl.res_found ? FND_W'(k_r + CNT_W'(1)) : '0;
      res_pal_r    <= ctl.res_pal;
      res_total_r  <= TOT_W'(count_r);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_total_r, res_pal_r, res_found_r, res_status_r};

endmodule

FILE: rtl/olte_ctrl.sv
// controller state machine: sequences shifts, scans and compares per command
// depends on olte_pkg; drives olte_datapath

module olte_ctrl
  import olte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CMD_W-1:0] in_cmd,
  input  dp_stat_t         stat,
  output dp_ctl_t          ctl
);

  state_t  state_r, state_nxt;
  cmd_t    cmd_r, cmd_nxt;
  status_t stat_r, stat_nxt;
  logic    fnd_r, fnd_nxt;
  logic    pal_r, pal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_INS_FRONT;
      stat_r  <= ST_OK;
      fnd_r   <= 1'b0;
      pal_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      stat_r  <= stat_nxt;
      fnd_r   <= fnd_nxt;
      pal_r   <= pal_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    stat_nxt  = stat_r;
    fnd_nxt   = fnd_r;
    pal_nxt   = pal_r;
    in_tready = 1'b0;
    ctl       = '0;
    ctl.res_status = stat_r;
    ctl.res_found  = fnd_r;
    ctl.res_pal    = pal_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          cmd_nxt     = cmd_t'(in_cmd);
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        stat_nxt = ST_OK;
        fnd_nxt  = 1'b0;
        pal_nxt  = 1'b0;
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
            if (stat.full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_FIN;
            end else if (cmd_r == CMD_INS_AT && !stat.ins_pos_ok) begin
              stat_nxt  = ST_NOT_FOUND;
              state_nxt = S_FIN;
            end else begin
              ctl.k_op = K_COUNT;
              if (cmd_r == CMD_INS_FRONT) begin
                ctl.j_op = J_ZERO;
              end else if (cmd_r == CMD_INS_END) begin
                ctl.j_op = J_COUNT;
              end else begin
                ctl.j_op = J_POSM1;
              end
              state_nxt = S_UP_CHK;
            end
          end
          CMD_DEL_AT: begin
            if (stat.del_pos_ok) begin
              ctl.k_op  = K_POSM1;
              state_nxt = S_DN_CHK;
            end else begin
              stat_nxt  = ST_NOT_FOUND;
              state_nxt = S_FIN;
            end
          end
          CMD_DEL_VAL, CMD_SEARCH: begin
            ctl.k_op  = K_ZERO;
            state_nxt = S_SC_CHK;
          end
          CMD_PALIN: begin
            if (stat.pal_go) begin
              ctl.k_op  = K_ZERO;
              ctl.j_op  = J_LAST;
              state_nxt = S_PA_RDA;
            end else begin
              pal_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          end
          default: begin
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_FIN;
          end
        endcase
      end

      // open a gap: move entries up from the tail down to the target
      S_UP_CHK: begin
        if (stat.k_gt_j) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_KM1;
          state_nxt  = S_UP_WR;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_val  = 1'b1;
          ctl.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end
      end

      S_UP_WR: begin
        ctl.wr_en = 1'b1;
        ctl.k_op  = K_DEC;
        state_nxt = S_UP_CHK;
      end

      // close the gap: move entries down toward the removed slot
      S_DN_CHK: begin
        if (stat.kp1_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_KP1;
          state_nxt  = S_DN_WR;
        end else begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end
      end

      S_DN_WR: begin
        ctl.wr_en = 1'b1;
        ctl.k_op  = K_INC;
        state_nxt = S_DN_CHK;
      end

      // linear scan for the first match
      S_SC_CHK: begin
        if (stat.k_lt_cnt) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_K;
          state_nxt  = S_SC_CMP;
        end else begin
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_FIN;
        end
      end

      S_SC_CMP: begin
        if (stat.match) begin
          if (cmd_r == CMD_SEARCH) begin
            fnd_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DN_CHK;
          end
        end else begin
          ctl.k_op  = K_INC;
          state_nxt = S_SC_CHK;
        end
      end

      // compare pairs from both ends toward the middle
      S_PA_RDA: begin
        if (stat.k_lt_j) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_K;
          state_nxt  = S_PA_RDB;
        end else begin
          pal_nxt   = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_PA_RDB: begin
        ctl.hold_ld = 1'b1;
        ctl.rd_en   = 1'b1;
        ctl.rd_sel  = RD_J;
        state_nxt   = S_PA_CMP;
      end

      S_PA_CMP: begin
        if (stat.differ) begin
          state_nxt = S_FIN;
        end else begin
          ctl.k_op  = K_INC;
          ctl.j_op  = J_DEC;
          state_nxt = S_PA_RDA;
        end
      end

      S_FIN: begin
        if (!stat.out_busy) begin
          ctl.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ordered_list_table_engine.sv
// top level of the ordered list table engine
// depends on olte_pkg, olte_ctrl and olte_datapath
//
// keeps an ordered list of up to DEPTH (32) signed words and runs one command
// per input transfer: insert front/end/at, delete value/at, search, palindrome
// input channel: in_tuser carries the command, in_tdata the value and position
// result channel: one transfer per command with status, found position,
// palindrome flag and the entry count after the command
// inserts and deletes do one store read and one store write per shifted
// entry, a scan does one store read and one compare per entry, and the
// palindrome check does two store reads and one compare per pair; the
// store has a single read and a single write port
// one command is worked at a time; in_tready is high only while idle
// the result sits in an output register, so a new command is taken while the
// previous result waits; a stalled receiver holds the next result back
// reset clears the entry count and the output valid; store contents are
// left as they are and only entries below the count are ever read

module ordered_list_table_engine
  import olte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // item_value[31:0], item_position[39:32]
  input  logic [CMD_W-1:0]      in_tuser,   // command[2:0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], found_position[7:2],
                                            // is_palindrome[8], entry_total[14:9]
);

  dp_ctl_t  ctl;    // commands from the state machine
  dp_stat_t stat;   // compare results and flags back to it

  olte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .stat      (stat),
    .ctl       (ctl)
  );

  // value and position are latched on the input transfer
  olte_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .stat        (stat),
    .in_value    (in_tdata[VAL_W-1:0]),
    .in_position (in_tdata[VAL_W+POS_W-1:VAL_W]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

FILE: rtl/olte_port_chk.sv
// port-level checks for the ordered list table engine, bound to the top level
// depends on olte_pkg

module olte_port_chk
  import olte_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // one command at a time: no transfer right after an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in progress");

  // a refused insert reports a full list
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STS_W'(ST_FULL) |->
      out_tdata[14:9] == TOT_W'(DEPTH))
    else $error("full status with list not full");

  // a found position is reported only with ok status and within the list
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:2] != '0 |->
      out_tdata[1:0] == STS_W'(ST_OK) && out_tdata[7:2] <= out_tdata[14:9])
    else $error("found position inconsistent with status or count");

endmodule

bind ordered_list_table_engine olte_port_chk u_port_chk (.*);
